### rtl/mm_pkg.sv
// Shared widths, register indexes and types for the matrix multiply block.
`default_nettype none

package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int EL_W        = 16;
	localparam int PROD_W      = 32;
	localparam int PV_W        = 35;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int POS_W       = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

	typedef struct packed {
		logic             first;
		logic             last;
		logic             fin;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} mm_tag_t;

endpackage

`default_nettype wire

### rtl/mm_if.sv
// Item channels of the matrix multiply block: input elements and product elements.
`default_nettype none

interface mm_in_if
	import mm_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [EL_W-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

interface mm_out_if
	import mm_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [PV_W-1:0] product_value;
	logic [POS_W-1:0]       out_row;
	logic [POS_W-1:0]       out_col;
	logic                   last_result;

	modport source (output valid, output product_value, output out_row, output out_col,
		output last_result, input ready);
	modport sink (input valid, input product_value, input out_row, input out_col,
		input last_result, output ready);
endinterface

`default_nettype wire

### rtl/mm_mac.sv
// Shared multiply-accumulate unit: product stage, accumulator and output saturation.
`default_nettype none

module mm_mac
	import mm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic                   v_in,
	input  wire mm_tag_t                tag_in,
	input  wire logic signed [EL_W-1:0] a_in,
	input  wire logic signed [EL_W-1:0] b_in,
	output logic                        done,
	output mm_tag_t                     done_tag,
	output logic signed [PV_W-1:0]      done_value
);

	localparam int ACC_W = (33 + $clog2(MAX_DIM) > 36) ? 33 + $clog2(MAX_DIM) : 36;

	logic                     v_s2;
	logic                     v_s3;
	mm_tag_t                  tag_s2;
	mm_tag_t                  tag_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_in;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2  <= tag_in;
			prod_s2 <= PROD_W'(a_in * b_in);
			tag_s3  <= tag_s2;
			if (v_s2) begin
				if (tag_s2.first) begin
					acc_q <= ACC_W'(prod_s2);
				end else begin
					acc_q <= acc_q + ACC_W'(prod_s2);
				end
			end
		end
	end

	// saturate when the bits above the 35-bit range disagree with the sign
	assign ovf        = (|acc_q[ACC_W-1:PV_W-1]) && !(&acc_q[ACC_W-1:PV_W-1]);
	assign done       = v_s3 && tag_s3.last;
	assign done_tag   = tag_s3;
	assign done_value = ovf ? {acc_q[ACC_W-1], {(PV_W-1){~acc_q[ACC_W-1]}}}
		: acc_q[PV_W-1:0];

endmodule

`default_nettype wire

### rtl/matrix_multiply_top.sv
// Top level of the matrix multiply block: loader, stores, MAC sequencer and result register.
`default_nettype none

// Loads A (rows_a x inner_size) then B (inner_size x cols_b) row-major at one
// element item per cycle into two on-chip stores. After the last B element the
// input is not ready while the sequencer issues one multiply-accumulate per
// cycle through the single shared MAC, rows x cols x inner of them, with a size
// of zero taken as one and a size above MAX_DIM taken as MAX_DIM. Each product
// element passes the operand registers, product stage, accumulator and result
// register after its last multiply-accumulate is issued, and is offered in
// row-major order with last_result on the final one; the input is ready again
// in the cycle after the last issue. A stalled result pauses the sequencer and
// the MAC pipeline. Register writes restart loading at the first element of A.
module matrix_multiply_top
	import mm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	mm_in_if.sink                     elements,
	mm_out_if.source                  products
);

	localparam int IW    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       rows_a_q;
	logic [CFG_W-1:0]       inner_size_q;
	logic [CFG_W-1:0]       cols_b_q;
	logic [IW-1:0]          nr_l;
	logic [IW-1:0]          nk_l;
	logic [IW-1:0]          nc_l;
	logic                   phase_q;
	logic [IW-1:0]          r_q;
	logic [IW-1:0]          c_q;
	logic [IW-1:0]          r_lim;
	logic [IW-1:0]          c_lim;
	logic                   accept;
	logic                   load_last;
	logic [AW-1:0]          wr_addr;
	logic [IW-1:0]          i_q;
	logic [IW-1:0]          j_q;
	logic [IW-1:0]          k_q;
	logic [AW-1:0]          rd_addr_a;
	logic [AW-1:0]          rd_addr_b;
	logic                   issue;
	logic                   adv;
	logic                   v_s1;
	mm_tag_t                tag_s1;
	logic signed [EL_W-1:0] a_s1;
	logic signed [EL_W-1:0] b_s1;
	logic signed [EL_W-1:0] store_a [DEPTH];
	logic signed [EL_W-1:0] store_b [DEPTH];
	logic                   mac_done;
	mm_tag_t                mac_tag;
	logic signed [PV_W-1:0] mac_value;
	logic                   out_valid_q;
	logic signed [PV_W-1:0] out_value_q;
	logic [POS_W-1:0]       out_row_q;
	logic [POS_W-1:0]       out_col_q;
	logic                   out_last_q;

	function automatic logic [IW-1:0] lim_of(input logic [CFG_W-1:0] v);
		logic [IW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > MAX_DIM) begin
			r = IW'(MAX_DIM - 1);
		end else begin
			r = IW'(int'(v) - 1);
		end
		return r;
	endfunction

	assign nr_l = lim_of(rows_a_q);
	assign nk_l = lim_of(inner_size_q);
	assign nc_l = lim_of(cols_b_q);

	// loader: A walks rows_a x inner_size, B walks inner_size x cols_b
	assign r_lim          = phase_q ? nk_l : nr_l;
	assign c_lim          = phase_q ? nc_l : nk_l;
	assign elements.ready = (state_q == ST_LOAD);
	assign accept         = elements.valid && elements.ready;
	assign load_last      = phase_q && (r_q == r_lim) && (c_q == c_lim);
	assign wr_addr        = AW'(int'(r_q) * MAX_DIM) + AW'(c_q);

	assign adv       = !out_valid_q || products.ready;
	assign issue     = (state_q == ST_CALC) && adv;
	assign rd_addr_a = AW'(int'(i_q) * MAX_DIM) + AW'(k_q);
	assign rd_addr_b = AW'(int'(k_q) * MAX_DIM) + AW'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			rows_a_q     <= CFG_W'(2);
			inner_size_q <= CFG_W'(2);
			cols_b_q     <= CFG_W'(2);
			phase_q      <= 1'b0;
			r_q          <= '0;
			c_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS_A:     rows_a_q <= cfg_data;
					CFG_INNER_SIZE: inner_size_q <= cfg_data;
					CFG_COLS_B:     cols_b_q <= cfg_data;
					default: ;
				endcase
				phase_q <= 1'b0;
				r_q     <= '0;
				c_q     <= '0;
			end else if (accept) begin
				if (c_q == c_lim) begin
					c_q <= '0;
					if (r_q == r_lim) begin
						r_q     <= '0;
						phase_q <= ~phase_q;
						if (phase_q) begin
							state_q <= ST_CALC;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
						end
					end else begin
						r_q <= r_q + 1'b1;
					end
				end else begin
					c_q <= c_q + 1'b1;
				end
			end

			if (adv) begin
				v_s1 <= issue;
			end
			if (issue) begin
				if (k_q == nk_l) begin
					k_q <= '0;
					if (j_q == nc_l) begin
						j_q <= '0;
						if (i_q == nr_l) begin
							i_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end

			if (adv && mac_done) begin
				out_valid_q <= 1'b1;
			end else if (products.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !phase_q) begin
			store_a[wr_addr] <= elements.element_value;
		end
		if (accept && phase_q) begin
			store_b[wr_addr] <= elements.element_value;
		end
		if (adv) begin
			a_s1         <= store_a[rd_addr_a];
			b_s1         <= store_b[rd_addr_b];
			tag_s1.first <= (k_q == '0);
			tag_s1.last  <= (k_q == nk_l);
			tag_s1.fin   <= (k_q == nk_l) && (j_q == nc_l) && (i_q == nr_l);
			tag_s1.row   <= POS_W'(i_q);
			tag_s1.col   <= POS_W'(j_q);
		end
		if (adv && mac_done) begin
			out_value_q <= mac_value;
			out_row_q   <= mac_tag.row;
			out_col_q   <= mac_tag.col;
			out_last_q  <= mac_tag.fin;
		end
	end

	mm_mac #(
		.MAX_DIM(MAX_DIM)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.v_in      (v_s1),
		.tag_in    (tag_s1),
		.a_in      (a_s1),
		.b_in      (b_s1),
		.done      (mac_done),
		.done_tag  (mac_tag),
		.done_value(mac_value)
	);

	assign products.valid         = out_valid_q;
	assign products.product_value = out_value_q;
	assign products.out_row       = out_row_q;
	assign products.out_col       = out_col_q;
	assign products.last_result   = out_last_q;

`ifndef SYNTH
	a_calc_after_b: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && load_last && !cfg_we) |=> (state_q == ST_CALC))
		else $error("sequencer did not start after last B element");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_done && mac_tag.fin) |-> (mac_tag.row == POS_W'(nr_l))
			&& (mac_tag.col == POS_W'(nc_l)))
		else $error("final product element at wrong position");

	a_mac_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_done && !adv) |=> (mac_done && $stable(mac_value)))
		else $error("MAC result lost under output stall");

	a_no_load_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> !(accept && phase_q))
		else $error("B store written during calculation");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the matrix multiply block: streamed A and B, predicted products.
`default_nettype none

module tb;
	import mm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = MAX_DIM_DEF;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam longint PV_MAX = (longint'(1) <<< (PV_W - 1)) - 1;
	localparam longint PV_MIN = -PV_MAX - 1;

	typedef logic signed [EL_W-1:0] elem_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0] cfg_val_t;

	typedef struct {
		logic signed [PV_W-1:0] value;
		logic [POS_W-1:0]       row;
		logic [POS_W-1:0]       col;
		logic                   last;
	} product_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	cfg_val_t cfg_data;

	mm_in_if element_ch ();
	mm_out_if product_ch ();

	matrix_multiply_top #(
		.MAX_DIM(MAX_DIM)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.elements(element_ch),
		.products(product_ch)
	);

	// predictor state
	cfg_val_t size_rows = 4'd2;
	cfg_val_t size_inner = 4'd2;
	cfg_val_t size_cols = 4'd2;
	elem_t mat_a [STORE_DEPTH];
	elem_t mat_b [STORE_DEPTH];
	int unsigned loaded = 0;
	product_item_t expected_products [$];

	int unsigned src_idle_pct = 31;
	int unsigned sink_idle_pct = 59;
	logic stall_request = 1'b0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned clamp_size(input cfg_val_t v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return 32'(v);
	endfunction

	function automatic int unsigned pass_length();
		int unsigned nk;
		nk = clamp_size(size_inner);
		return nk * (clamp_size(size_rows) + clamp_size(size_cols));
	endfunction

	function automatic void load_and_multiply(input elem_t v);
		int unsigned nr, nk, nc, na, nb, idx;
		longint acc;
		product_item_t p;
		nr = clamp_size(size_rows);
		nk = clamp_size(size_inner);
		nc = clamp_size(size_cols);
		na = nr * nk;
		nb = nk * nc;
		if (loaded >= na + nb) loaded = 0;
		if (loaded < na) begin
			mat_a[(loaded / nk) * MAX_DIM + loaded % nk] = v;
		end else begin
			idx = loaded - na;
			mat_b[(idx / nc) * MAX_DIM + idx % nc] = v;
		end
		loaded++;
		if (loaded < na + nb) return;
		loaded = 0;
		for (int unsigned i = 0; i < nr; i++) begin
			for (int unsigned j = 0; j < nc; j++) begin
				acc = 0;
				for (int unsigned k = 0; k < nk; k++) begin
					acc += longint'(mat_a[i * MAX_DIM + k]) * longint'(mat_b[k * MAX_DIM + j]);
				end
				if (acc > PV_MAX) acc = PV_MAX;
				if (acc < PV_MIN) acc = PV_MIN;
				p.value = PV_W'(acc);
				p.row = POS_W'(i);
				p.col = POS_W'(j);
				p.last = (i == nr - 1) && (j == nc - 1);
				expected_products.push_back(p);
			end
		end
	endfunction

	function automatic elem_t rand_element();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return elem_t'($urandom);
		endcase
	endfunction

	function automatic cfg_val_t rand_size();
		if ($urandom_range(9) < 8) return cfg_val_t'($urandom_range(0, 3));
		return cfg_val_t'($urandom_range(0, 15));
	endfunction

	task automatic offer_element(input elem_t value);
		cfg_we <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			element_ch.valid <= 1'b0;
			@(posedge clk);
		end
		element_ch.valid <= 1'b1;
		element_ch.element_value <= value;
		@(posedge clk);
		while (!element_ch.ready) @(posedge clk);
		load_and_multiply(value);
	endtask

	// write enable stays up until the next item is offered
	task automatic write_register(input cfg_idx_t index, input cfg_val_t value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		case (index)
			CFG_ROWS_A: size_rows = value;
			CFG_INNER_SIZE: size_inner = value;
			CFG_COLS_B: size_cols = value;
			default: ;
		endcase
		loaded = 0;
	endtask

	task automatic settle();
		element_ch.valid <= 1'b0;
		while (expected_products.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) offer_element(rand_element());
	endtask

	task automatic test_default_sizes();
		elem_t vals [8] = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
		foreach (vals[n]) offer_element(vals[n]);
		settle();
	endtask

	// zero acts as one, above the maximum acts as the maximum
	task automatic test_size_limits();
		elem_t vals [9] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
			16'sh0001, 16'sh0100, 16'shFF00, 16'sh5555};
		write_register(CFG_ROWS_A, 4'd0);
		write_register(CFG_INNER_SIZE, 4'd1);
		write_register(CFG_COLS_B, 4'd15);
		foreach (vals[n]) offer_element(vals[n]);
		settle();
	endtask

	// any register write during a load restarts at the first element of A
	task automatic test_restart();
		write_register(CFG_ROWS_A, 4'd1);
		write_register(CFG_INNER_SIZE, 4'd1);
		write_register(CFG_COLS_B, 4'd1);
		offer_element(16'sh1234);
		settle();
		write_register(CFG_SPARE, 4'd0);
		offer_element(16'sh0300);
		offer_element(16'shFE00);
		settle();
		offer_element(16'sh7FFF);
		settle();
		write_register(CFG_INNER_SIZE, 4'd1);
		offer_element(16'sh8000);
		offer_element(16'sh8000);
		settle();
	endtask

	// full-size product: the most results a pass can give
	task automatic test_largest();
		write_register(CFG_ROWS_A, 4'd8);
		write_register(CFG_INNER_SIZE, 4'd1);
		write_register(CFG_COLS_B, 4'd8);
		send_random(pass_length());
		settle();
	endtask

	task automatic test_backpressure();
		write_register(CFG_ROWS_A, 4'd2);
		write_register(CFG_INNER_SIZE, 4'd3);
		write_register(CFG_COLS_B, 4'd2);
		stall_request = 1'b1;
		send_random(2 * pass_length());
		settle();
	endtask

	task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned item_goal);
		int unsigned sent;
		int unsigned total;
		int unsigned count;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < item_goal) begin
			settle();
			write_register(CFG_ROWS_A, rand_size());
			write_register(CFG_INNER_SIZE, rand_size());
			write_register(CFG_COLS_B, rand_size());
			total = pass_length();
			for (int unsigned p = $urandom_range(1, 2); p > 0; p--) begin
				count = total;
				if (total > 1 && $urandom_range(9) == 0) count = $urandom_range(1, total - 1);
				send_random(count);
				sent += count;
				if (count != total) break;
			end
		end
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROWS_A;
		cfg_data <= '0;
		element_ch.valid <= 1'b0;
		element_ch.element_value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_sizes();
		test_size_limits();
		test_restart();
		test_largest();
		test_backpressure();
		test_random(31, 59, 16);
		test_random(59, 31, 16);
		test_random(0, 0, 16);
		settle();
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	always begin
		@(posedge clk);
		if (stall_request) begin
			stall_request = 1'b0;
			repeat (HOLD_CYCLES) begin
				product_ch.ready <= 1'b0;
				@(posedge clk);
			end
		end
		product_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		product_item_t exp_item;
		if (product_ch.valid && product_ch.ready) begin
			if (expected_products.size() == 0) begin
				$error("unexpected product item: row %0d col %0d value %0d",
					product_ch.out_row, product_ch.out_col, product_ch.product_value);
				mismatches++;
			end else begin
				exp_item = expected_products.pop_front();
				if (product_ch.product_value !== exp_item.value) begin
					$error("product_value: expected %0d, got %0d", exp_item.value,
						product_ch.product_value);
					mismatches++;
				end
				if (product_ch.out_row !== exp_item.row) begin
					$error("out_row: expected %0d, got %0d", exp_item.row, product_ch.out_row);
					mismatches++;
				end
				if (product_ch.out_col !== exp_item.col) begin
					$error("out_col: expected %0d, got %0d", exp_item.col, product_ch.out_col);
					mismatches++;
				end
				if (product_ch.last_result !== exp_item.last) begin
					$error("last_result: expected %0d, got %0d", exp_item.last,
						product_ch.last_result);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((element_ch.valid && element_ch.ready) || (product_ch.valid && product_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

endmodule

`default_nettype wire
